>>> hw/rtl/mbva_pkg.sv
// ----------------------------------------------------------------------------
// mbva_pkg
// Types, codes and helpers shared by the MIDI byte voice allocator.
// ----------------------------------------------------------------------------
package mbva_pkg;

  // Status nibbles of channel messages
  localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
  localparam logic [3:0] ST_NOTE_ON   = 4'h9;
  localparam logic [3:0] ST_CONTROL   = 4'hB;
  localparam logic [3:0] ST_PROGRAM   = 4'hC;
  localparam logic [3:0] ST_PRESSURE  = 4'hD;
  localparam logic [3:0] ST_BEND      = 4'hE;

  localparam logic [7:0] SYS_FIRST      = 8'hF0;
  localparam logic [7:0] REALTIME_FIRST = 8'hF8;

  // Controller numbers with a meaning of their own
  localparam logic [6:0] CC_MODWHEEL    = 7'd1;
  localparam logic [6:0] CC_PRESET_LOAD = 7'd32;
  localparam logic [6:0] CC_PRESET_SAVE = 7'd33;
  localparam logic [6:0] CC_SUSTAIN     = 7'd64;

  // Configuration register indexes
  localparam logic CFG_LISTEN_CHANNEL = 1'b0;
  localparam logic CFG_VOICE_MODE     = 1'b1;

  // Voice modes
  localparam logic [2:0] MODE_FIXED_LAST  = 3'd3;
  localparam logic [2:0] MODE_ROUND_ROBIN = 3'd4;
  localparam logic [2:0] MODE_RANDOM      = 3'd5;
  localparam logic [2:0] MODE_OCTAVE      = 3'd6;

  // Octave by reciprocal: (note * 171) >> 11 equals note / 12 for notes 0..127
  localparam logic [7:0] OCT_RECIP = 8'd171;
  localparam int         OCT_SHIFT = 11;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MSG_NONE,
    MSG_CTRL,
    MSG_NOTE_ON,
    MSG_NOTE_OFF,
    MSG_BEND,
    MSG_TOUCH
  } msg_kind_t;

  typedef struct packed {
    msg_kind_t  kind;
    logic [6:0] d1;
    logic [6:0] d2;
  } msg_entry_t;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_ASSIGNED    = 4'd1,
    EV_UNASSIGNED  = 4'd2,
    EV_NOTE_OFF    = 4'd3,
    EV_MODWHEEL    = 4'd4,
    EV_SUSTAIN     = 4'd5,
    EV_PRESET_LOAD = 4'd6,
    EV_PRESET_SAVE = 4'd7,
    EV_CONTROL     = 4'd8,
    EV_BEND        = 4'd9,
    EV_TOUCH       = 4'd10
  } event_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DECIDE,
    BK_MOD,
    BK_APPLY
  } back_state_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] t;
    t = s >> 1;
    if (s[0]) t = t ^ LFSR_TAPS;
    return t;
  endfunction

endpackage

>>> hw/rtl/mbva_byte_if.sv
// ----------------------------------------------------------------------------
// mbva_byte_if
// Received MIDI byte channel.
// ----------------------------------------------------------------------------
interface mbva_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/mbva_event_if.sv
// ----------------------------------------------------------------------------
// mbva_event_if
// Event channel: one beat per received byte.
// ----------------------------------------------------------------------------
interface mbva_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [1:0]  voice_index;
  logic [6:0]  note_number;
  logic [6:0]  controller_number;
  logic [13:0] event_value;
  logic [3:0]  gate_mask;
  logic [3:0]  held_mask;

  modport source (output valid, output event_kind, output voice_index,
                  output note_number, output controller_number,
                  output event_value, output gate_mask, output held_mask,
                  input ready);
  modport sink   (input valid, input event_kind, input voice_index,
                  input note_number, input controller_number,
                  input event_value, input gate_mask, input held_mask,
                  output ready);
endinterface

>>> hw/rtl/mbva_front.sv
// ----------------------------------------------------------------------------
// mbva_front
// Running-status parser and channel filter; one queue entry per byte.
// ----------------------------------------------------------------------------
module mbva_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [4:0]         listen_channel,
  mbva_byte_if.sink          rx,
  output logic               push_valid,
  output mbva_pkg::msg_entry_t push_data,
  input  logic               push_ready
);

  logic [7:0] running_status, running_status_next;
  logic [1:0] bytes_needed, bytes_needed_next;
  logic       bytes_held, bytes_held_next;
  logic [6:0] first_data, first_data_next;

  logic       dispatch;
  logic [6:0] d1, d2;
  logic       chan_ok;
  logic [3:0] st_type;

  assign rx.ready   = push_ready;
  assign push_valid = rx.valid;

  assign st_type = running_status[7:4];
  assign chan_ok = (listen_channel == 5'd0) ||
                   (listen_channel == (5'({1'b0, running_status[3:0]}) + 5'd1));

  always_comb begin
    running_status_next = running_status;
    bytes_needed_next   = bytes_needed;
    bytes_held_next     = bytes_held;
    first_data_next     = first_data;
    dispatch            = 1'b0;
    d1                  = first_data;
    d2                  = 7'd0;

    if (rx.rx_byte >= mbva_pkg::REALTIME_FIRST) begin
      // realtime: parser untouched
    end else if (rx.rx_byte >= mbva_pkg::SYS_FIRST) begin
      bytes_needed_next = 2'd0;
      bytes_held_next   = 1'b0;
    end else if (rx.rx_byte[7]) begin
      running_status_next = rx.rx_byte;
      bytes_held_next     = 1'b0;
      bytes_needed_next   = (rx.rx_byte[7:4] == mbva_pkg::ST_PROGRAM ||
                             rx.rx_byte[7:4] == mbva_pkg::ST_PRESSURE) ? 2'd1 : 2'd2;
    end else if (bytes_needed != 2'd0) begin
      if (!bytes_held) begin
        first_data_next = rx.rx_byte[6:0];
        if (bytes_needed == 2'd1) begin
          dispatch = 1'b1;
          d1       = rx.rx_byte[6:0];
        end else begin
          bytes_held_next = 1'b1;
        end
      end else begin
        bytes_held_next = 1'b0;
        dispatch        = 1'b1;
        d2              = rx.rx_byte[6:0];
      end
    end

    push_data.d1   = d1;
    push_data.d2   = d2;
    push_data.kind = mbva_pkg::MSG_NONE;
    if (dispatch && chan_ok) begin
      case (st_type)
        mbva_pkg::ST_CONTROL:  push_data.kind = mbva_pkg::MSG_CTRL;
        mbva_pkg::ST_NOTE_ON:  push_data.kind = (d2 != 7'd0) ? mbva_pkg::MSG_NOTE_ON
                                                             : mbva_pkg::MSG_NOTE_OFF;
        mbva_pkg::ST_NOTE_OFF: push_data.kind = mbva_pkg::MSG_NOTE_OFF;
        mbva_pkg::ST_BEND:     push_data.kind = mbva_pkg::MSG_BEND;
        mbva_pkg::ST_PRESSURE: push_data.kind = mbva_pkg::MSG_TOUCH;
        default:               push_data.kind = mbva_pkg::MSG_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= 8'd0;
      bytes_needed   <= 2'd0;
      bytes_held     <= 1'b0;
      first_data     <= 7'd0;
    end else if (rx.valid && push_ready) begin
      running_status <= running_status_next;
      bytes_needed   <= bytes_needed_next;
      bytes_held     <= bytes_held_next;
      first_data     <= first_data_next;
    end
  end

endmodule

>>> hw/rtl/mbva_queue.sv
// ----------------------------------------------------------------------------
// mbva_queue
// Short FIFO of classified messages between parser and allocator.
// ----------------------------------------------------------------------------
module mbva_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  input  mbva_pkg::msg_entry_t push_data,
  output logic                 push_ready,
  output logic                 pop_valid,
  output mbva_pkg::msg_entry_t pop_data,
  input  logic                 pop_ready
);

  localparam int PW = $clog2(mbva_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mbva_pkg::QUEUE_DEPTH + 1);

  mbva_pkg::msg_entry_t slots [mbva_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(mbva_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PW'(mbva_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == PW'(mbva_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !do_push)
        count <= count - 1'b1;
    end
  end

endmodule

>>> hw/rtl/mbva_back.sv
// ----------------------------------------------------------------------------
// mbva_back
// Voice allocator: note mapping, gates, sustain, and the event register.
// ----------------------------------------------------------------------------
module mbva_back #(
  parameter int VOICE_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           alloc_mode,
  input  logic                 q_valid,
  input  mbva_pkg::msg_entry_t q_data,
  output logic                 q_ready,
  mbva_event_if.source         tx
);

  localparam int VIW = $clog2(VOICE_COUNT);
  localparam int CW  = $clog2(VOICE_COUNT + 1);
  localparam int RW  = CW + 1;

  mbva_pkg::back_state_t state, state_next;
  mbva_pkg::msg_entry_t  cur;

  // voice state
  logic [6:0]             mapped_note [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] mapped_valid;
  logic [6:0]             playing_note [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] playing_valid;
  logic [VOICE_COUNT-1:0] voice_gate, pedal_down, pedal_held;
  logic [VIW-1:0]         rotation_pointer;
  logic [15:0]            random_shift;

  // remainder unit
  logic [15:0]   dividend;
  logic [RW-1:0] divisor, rem, rem_step, rem_shift;
  logic [3:0]    bit_count;
  logic          none_free;

  // next values on apply
  logic [6:0]             mnote_next [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] mvalid_next;
  logic [6:0]             pnote_next [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] pvalid_next;
  logic [VOICE_COUNT-1:0] gate_next, held_next, down_next;
  logic [VIW-1:0]         rot_next;

  logic [CW-1:0]  idle_voices, scan_count;
  logic           pick_ok;
  logic [VIW-1:0] pick_v, off_v, ev_v;
  logic           off_found;
  logic [14:0]    oct_prod;
  logic [3:0]     octave;

  mbva_pkg::event_kind_t ev_kind;
  logic [6:0]            ev_note, ev_ctrl;
  logic [13:0]           ev_value;
  logic [VIW+1:0]        ev_v_ext;
  logic [VOICE_COUNT+3:0] gate_ext, held_ext;

  logic        out_valid;
  logic [3:0]  out_kind;
  logic [1:0]  out_voice;
  logic [6:0]  out_note, out_ctrl;
  logic [13:0] out_value;
  logic [3:0]  out_gate, out_held;
  logic        apply_fire;

  assign tx.valid             = out_valid;
  assign tx.event_kind        = out_kind;
  assign tx.voice_index       = out_voice;
  assign tx.note_number       = out_note;
  assign tx.controller_number = out_ctrl;
  assign tx.event_value       = out_value;
  assign tx.gate_mask         = out_gate;
  assign tx.held_mask         = out_held;

  assign apply_fire = (state == mbva_pkg::BK_APPLY) && (!out_valid || tx.ready);

  // state machine
  always_ff @(posedge clk) begin
    if (rst) state <= mbva_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    case (state)
      mbva_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_ready    = 1'b1;
          state_next = mbva_pkg::BK_DECIDE;
        end
      end
      mbva_pkg::BK_DECIDE: begin
        if (cur.kind == mbva_pkg::MSG_NOTE_ON && alloc_mode == mbva_pkg::MODE_RANDOM)
          state_next = mbva_pkg::BK_MOD;
        else
          state_next = mbva_pkg::BK_APPLY;
      end
      mbva_pkg::BK_MOD: begin
        if (bit_count == 4'd0) state_next = mbva_pkg::BK_APPLY;
      end
      mbva_pkg::BK_APPLY: begin
        if (apply_fire) state_next = mbva_pkg::BK_IDLE;
      end
      default: state_next = mbva_pkg::BK_IDLE;
    endcase
  end

  // free voices
  always_comb begin
    idle_voices = '0;
    for (int v = 0; v < VOICE_COUNT; v++)
      if (!voice_gate[v]) idle_voices = idle_voices + 1'b1;
  end

  // restoring remainder, one dividend bit a cycle, MSB first
  assign rem_shift = {rem[RW-2:0], dividend[15]};
  assign rem_step  = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;

  always_ff @(posedge clk) begin
    if (state == mbva_pkg::BK_IDLE && q_valid) cur <= q_data;
    if (state == mbva_pkg::BK_DECIDE) begin
      dividend  <= mbva_pkg::lfsr_step(random_shift);
      none_free <= (idle_voices == '0);
      divisor   <= (idle_voices == '0) ? RW'(VOICE_COUNT) : RW'(idle_voices);
      rem       <= '0;
      bit_count <= 4'd15;
    end
    if (state == mbva_pkg::BK_MOD) begin
      rem       <= rem_step;
      dividend  <= {dividend[14:0], 1'b0};
      bit_count <= bit_count - 4'd1;
    end
  end

  // voice choice for a note-on
  assign oct_prod = 15'(cur.d1) * 15'(mbva_pkg::OCT_RECIP);
  assign octave   = oct_prod[14:mbva_pkg::OCT_SHIFT];

  always_comb begin
    pick_ok    = 1'b0;
    pick_v     = '0;
    scan_count = '0;
    if (alloc_mode <= mbva_pkg::MODE_FIXED_LAST) begin
      pick_ok = (int'(alloc_mode) < VOICE_COUNT);
      pick_v  = VIW'(alloc_mode);
    end else if (alloc_mode == mbva_pkg::MODE_ROUND_ROBIN) begin
      pick_ok = 1'b1;
      pick_v  = rotation_pointer;
    end else if (alloc_mode == mbva_pkg::MODE_RANDOM) begin
      pick_ok = 1'b1;
      if (none_free) begin
        pick_v = VIW'(rem);
      end else begin
        // rem-th free voice in ascending order
        for (int v = 0; v < VOICE_COUNT; v++) begin
          if (!voice_gate[v]) begin
            if (RW'(scan_count) == rem) pick_v = VIW'(v);
            scan_count = scan_count + 1'b1;
          end
        end
      end
    end else if (alloc_mode == mbva_pkg::MODE_OCTAVE) begin
      pick_ok = (octave >= 4'd1) && (octave <= 4'd4) && ((int'(octave) - 1) < VOICE_COUNT);
      pick_v  = VIW'(octave - 4'd1);
    end
  end

  // lowest voice mapped to the note
  always_comb begin
    off_found = 1'b0;
    off_v     = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (mapped_valid[v] && mapped_note[v] == cur.d1) begin
        off_found = 1'b1;
        off_v     = VIW'(v);
      end
    end
  end

  // effect of the current message
  always_comb begin
    mnote_next  = mapped_note;
    mvalid_next = mapped_valid;
    pnote_next  = playing_note;
    pvalid_next = playing_valid;
    gate_next   = voice_gate;
    held_next   = pedal_held;
    down_next   = pedal_down;
    rot_next    = rotation_pointer;
    ev_kind     = mbva_pkg::EV_NONE;
    ev_v        = '0;
    ev_note     = 7'd0;
    ev_ctrl     = 7'd0;
    ev_value    = 14'd0;
    case (cur.kind)
      mbva_pkg::MSG_CTRL: begin
        ev_ctrl  = cur.d1;
        ev_value = {7'd0, cur.d2};
        if (cur.d1 == mbva_pkg::CC_MODWHEEL) begin
          ev_kind = mbva_pkg::EV_MODWHEEL;
        end else if (cur.d1 == mbva_pkg::CC_SUSTAIN) begin
          ev_kind = mbva_pkg::EV_SUSTAIN;
          for (int v = 0; v < VOICE_COUNT; v++) begin
            down_next[v] = cur.d2[6];
            if (!cur.d2[6] && pedal_held[v]) begin
              held_next[v] = 1'b0;
              if (!playing_valid[v]) gate_next[v] = 1'b0;
            end
          end
        end else if (cur.d1 == mbva_pkg::CC_PRESET_LOAD) begin
          ev_kind = mbva_pkg::EV_PRESET_LOAD;
        end else if (cur.d1 == mbva_pkg::CC_PRESET_SAVE) begin
          ev_kind = mbva_pkg::EV_PRESET_SAVE;
        end else begin
          ev_kind = mbva_pkg::EV_CONTROL;
        end
      end
      mbva_pkg::MSG_NOTE_ON: begin
        ev_note = cur.d1;
        if (alloc_mode == mbva_pkg::MODE_ROUND_ROBIN)
          rot_next = (rotation_pointer == VIW'(VOICE_COUNT - 1)) ? '0
                                                               : rotation_pointer + 1'b1;
        if (pick_ok) begin
          for (int w = 0; w < VOICE_COUNT; w++)
            if (mapped_valid[w] && mapped_note[w] == cur.d1) mvalid_next[w] = 1'b0;
          mvalid_next[pick_v] = 1'b1;
          mnote_next[pick_v]  = cur.d1;
          pvalid_next[pick_v] = 1'b1;
          pnote_next[pick_v]  = cur.d1;
          gate_next[pick_v]   = 1'b1;
          held_next[pick_v]   = 1'b0;
          ev_kind             = mbva_pkg::EV_ASSIGNED;
          ev_v                = pick_v;
        end else begin
          ev_kind = mbva_pkg::EV_UNASSIGNED;
        end
      end
      mbva_pkg::MSG_NOTE_OFF: begin
        if (off_found) begin
          if (playing_valid[off_v] && playing_note[off_v] == cur.d1) begin
            if (pedal_down[off_v]) held_next[off_v] = 1'b1;
            else                   gate_next[off_v] = 1'b0;
            pvalid_next[off_v] = 1'b0;
          end
          mvalid_next[off_v] = 1'b0;
          ev_kind            = mbva_pkg::EV_NOTE_OFF;
          ev_v               = off_v;
          ev_note            = cur.d1;
        end
      end
      mbva_pkg::MSG_BEND: begin
        ev_kind  = mbva_pkg::EV_BEND;
        ev_value = {cur.d2, cur.d1};
      end
      mbva_pkg::MSG_TOUCH: begin
        ev_kind  = mbva_pkg::EV_TOUCH;
        ev_value = {7'd0, cur.d1};
      end
      default: ev_kind = mbva_pkg::EV_NONE;
    endcase
  end

  assign ev_v_ext = {2'b00, ev_v};
  assign gate_ext = {4'b0000, gate_next};
  assign held_ext = {4'b0000, held_next};

  // voice state and event register
  always_ff @(posedge clk) begin
    if (rst) begin
      mapped_valid     <= '0;
      playing_valid    <= '0;
      voice_gate       <= '0;
      pedal_down       <= '0;
      pedal_held       <= '0;
      rotation_pointer <= '0;
      random_shift     <= mbva_pkg::LFSR_SEED;
      out_valid        <= 1'b0;
    end else begin
      if (state == mbva_pkg::BK_DECIDE && state_next == mbva_pkg::BK_MOD)
        random_shift <= mbva_pkg::lfsr_step(random_shift);
      if (apply_fire) begin
        mapped_valid     <= mvalid_next;
        playing_valid    <= pvalid_next;
        voice_gate       <= gate_next;
        pedal_down       <= down_next;
        pedal_held       <= held_next;
        rotation_pointer <= rot_next;
        out_valid        <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      mapped_note  <= mnote_next;
      playing_note <= pnote_next;
      out_kind     <= ev_kind;
      out_voice    <= ev_v_ext[1:0];
      out_note     <= ev_note;
      out_ctrl     <= ev_ctrl;
      out_value    <= ev_value;
      out_gate     <= gate_ext[3:0];
      out_held     <= held_ext[3:0];
    end
  end

  // a voice held by the pedal keeps its gate open
  a_held_gated: assert property (@(posedge clk) disable iff (rst)
    (pedal_held & ~voice_gate) == '0)
    else $error("held voice with gate off");

  a_lfsr_alive: assert property (@(posedge clk) disable iff (rst)
    random_shift != 16'd0)
    else $error("random shift register stuck at zero");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    int'(rotation_pointer) < VOICE_COUNT)
    else $error("rotation pointer out of range");

  a_mod_only_note_on: assert property (@(posedge clk) disable iff (rst)
    (state == mbva_pkg::BK_MOD) |-> (cur.kind == mbva_pkg::MSG_NOTE_ON &&
                                      rem < divisor && divisor != '0))
    else $error("remainder unit running out of turn");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_ready |=> (state == mbva_pkg::BK_DECIDE))
    else $error("queue popped outside idle");

endmodule

>>> hw/rtl/midi_byte_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// midi_byte_voice_allocator_core
// MIDI byte parser with channel filter and four-voice note allocator.
//
//   channel   dir  beat carries
//   midi_in   in   rx_byte: one received MIDI byte
//   events    out  one event per byte: kind, voice, note, controller, value,
//                  gate and held masks
//   cfg_*     in   register write: 0 listen channel, 1 voice mode
//
// The parser takes a byte each cycle into a four-entry message queue. The
// allocator handles one byte at a time (pop, decide, apply); for a note-on in
// random mode a remainder unit picks a free voice, or any if none is free.
// Reset is synchronous and clears parser, queue and voice state; the random
// shift register is seeded. midi_in stalls when the queue is full; the
// allocator waits in apply while the event register is still occupied.
// ----------------------------------------------------------------------------
module midi_byte_voice_allocator_core #(
  parameter int VOICE_COUNT = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [4:0]   cfg_data,
  mbva_byte_if.sink    midi_in,
  mbva_event_if.source events
);

  logic [4:0] listen_channel;
  logic [2:0] alloc_mode;

  logic                 push_valid, push_ready;
  mbva_pkg::msg_entry_t push_data;
  logic                 pop_valid, pop_ready;
  mbva_pkg::msg_entry_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= 5'd0;
      alloc_mode     <= 3'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        mbva_pkg::CFG_LISTEN_CHANNEL: listen_channel <= cfg_data;
        mbva_pkg::CFG_VOICE_MODE:     alloc_mode     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  mbva_front u_front (
    .clk            (clk),
    .rst            (rst),
    .listen_channel (listen_channel),
    .rx             (midi_in),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .push_ready     (push_ready)
  );

  mbva_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  mbva_back #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .alloc_mode (alloc_mode),
    .q_valid    (pop_valid),
    .q_data     (pop_data),
    .q_ready    (pop_ready),
    .tx         (events)
  );

endmodule
